// ===== design/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants for the GHASH authenticator
// 128-bit block type, field widths and the GF(2^128) reduction constant.
// ----------------------------------------------------------------------------
package gha_pkg;

	localparam int BLK_W   = 128;
	localparam int HALF_W  = 64;
	localparam int LEN_W   = 29;
	localparam int LENB_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 160;
	localparam int DIGIT_W_DEFAULT = 16;

	typedef logic [BLK_W-1:0] blk_t;

	// x^128 = 1 + x + x^2 + x^7, with x^0 at the msb of the block
	localparam blk_t RED_POLY = {8'hE1, 120'd0};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_HIGH   = 2'd0,
		REG_KEY_LOW    = 2'd1,
		REG_WORD_ONE   = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_FINISH = 1'b1
	} item_kind_t;

endpackage

// ===== design/gha_digit_mul.sv =====
// ----------------------------------------------------------------------------
// gha_digit_mul: one digit step of a GF(2^128) multiply
// Horner step z' = z*x^D + d(x)*H, where d holds the next D coefficients of
// the multiplier, highest degree first.
// ----------------------------------------------------------------------------
module gha_digit_mul #(
	parameter int DIGIT_W = gha_pkg::DIGIT_W_DEFAULT
) (
	input  gha_pkg::blk_t        z,
	input  gha_pkg::blk_t        h,
	input  logic [DIGIT_W-1:0]   digit,
	output gha_pkg::blk_t        z_next
);
	import gha_pkg::*;

	localparam int EXT_W = BLK_W + DIGIT_W;

	logic [EXT_W-1:0] ext;
	blk_t             red;

	always_comb begin
		// multiply by x^D moves every coefficient D places toward the lsb
		ext = {{DIGIT_W{1'b0}}, z};
		for (int j = 0; j < DIGIT_W; j++) begin
			if (digit[DIGIT_W-1-j]) begin
				ext = ext ^ ({h, {DIGIT_W{1'b0}}} >> j);
			end
		end
		// fold the overflow terms x^(128+m) back in
		red = ext[EXT_W-1:DIGIT_W];
		for (int m = 0; m < DIGIT_W; m++) begin
			if (ext[DIGIT_W-1-m]) begin
				red = red ^ (RED_POLY >> m);
			end
		end
		z_next = red;
	end

endmodule

// ===== design/ghash_authenticator_core.sv =====
// ----------------------------------------------------------------------------
// ghash_authenticator_core: GCM-style GHASH digest engine
//
//   channel  direction  transfer carries
//   s_*      in         tuser: kind; tdata: block_high, block_low, message_length
//   m_*      out        tdata: digest_high, digest_low
//   cfg_*    in         register writes: key_high, key_low, length_at_word_one
//
// Each item is handled by the digit-serial multiplier, which processes one digit of
// the operand a cycle. After a data item the next transfer can land on the edge of
// its last digit. A finish item keeps the input closed through its last digit and
// through ST_DONE, which moves the digest into the output register; ST_DONE waits
// while that register still holds an untaken digest.
// Reset clears the accumulator, the key and the control state.
// ----------------------------------------------------------------------------
module ghash_authenticator_core #(
	parameter int DIGIT_W = gha_pkg::DIGIT_W_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [63:0] block_high, [127:64] block_low, [156:128] message_length
	input  logic [gha_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [63:0] digest_high, [127:64] digest_low
	output logic [gha_pkg::BLK_W-1:0]      m_tdata,
	input  logic                           cfg_we,
	input  logic [gha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gha_pkg::HALF_W-1:0]     cfg_data
);
	import gha_pkg::*;

	localparam int STEPS = BLK_W / DIGIT_W;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               fin_q;
	logic               word_one_q;
	logic [HALF_W-1:0]  key_high_q;
	logic [HALF_W-1:0]  key_low_q;
	blk_t               x_q;
	blk_t               z_q;
	blk_t               out_q;
	logic               out_vld_q;

	blk_t               z_next;
	blk_t               z_base;
	blk_t               len_blk;
	blk_t               operand;
	logic [LENB_W-1:0]  len_bits;
	logic               last_step;
	logic               in_xfer;
	logic               out_free;

	gha_digit_mul #(
		.DIGIT_W(DIGIT_W)
	) u_mul (
		.z      (z_q),
		.h      ({key_high_q, key_low_q}),
		.digit  (x_q[DIGIT_W-1:0]),
		.z_next (z_next)
	);

	assign last_step = (cnt_q == CNT_W'(STEPS - 1));
	assign s_tready  = (state_q == ST_IDLE) || (state_q == ST_RUN && last_step && !fin_q);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = {out_q[HALF_W-1:0], out_q[BLK_W-1:HALF_W]};

	// bit length as a big-endian word at byte offset 4 or 12
	assign len_bits = {s_tdata[BLK_W+LEN_W-1:BLK_W], 3'b000};
	assign len_blk  = word_one_q ? {32'd0, len_bits, 64'd0} : {96'd0, len_bits};
	assign operand  = (item_kind_t'(s_tuser) == KIND_FINISH) ? len_blk
		: {s_tdata[HALF_W-1:0], s_tdata[BLK_W-1:HALF_W]};
	// back-to-back data items fold into the product finishing this cycle
	assign z_base   = (state_q == ST_RUN) ? z_next : z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			word_one_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_WORD_ONE: word_one_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= z_base ^ operand;
		end else if (state_q == ST_RUN) begin
			x_q <= x_q >> DIGIT_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			fin_q     <= 1'b0;
			z_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (in_xfer) begin
				state_q <= ST_RUN;
				cnt_q   <= '0;
				fin_q   <= (item_kind_t'(s_tuser) == KIND_FINISH);
				z_q     <= '0;
			end else begin
				case (state_q)
					ST_IDLE: ;
					ST_RUN: begin
						z_q   <= z_next;
						cnt_q <= cnt_q + 1'b1;
						if (last_step) begin
							state_q <= fin_q ? ST_DONE : ST_IDLE;
						end
					end
					ST_DONE: begin
						if (out_free) begin
							z_q     <= '0;
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= z_q;
		end
	end

	// an accepted item always starts its multiply from the first digit
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_RUN && cnt_q == '0))
		else $error("item accepted without starting a multiply");

	// no new item while a multiply is still mid-way
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !last_step) |-> !s_tready)
		else $error("input ready during multiply");

	// handing off a digest clears the accumulator and raises the output
	a_digest_hand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (z_q == '0 && m_tvalid && state_q == ST_IDLE))
		else $error("digest handoff failed");

	// a finish item never releases the input early
	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && fin_q) |-> !s_tready)
		else $error("input ready during finish");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for ghash_authenticator_core
// Streams data blocks and finish items through the core under several
// handshake throttling mixes and key settings. A bit-level GF(2^128) model
// predicts every digest; digests are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
	import gha_pkg::*;

	localparam int                  SETTLE_CYCLES = 32;
	localparam int                  STALL_LIMIT   = 4000;
	localparam int                  HOLD_CYCLES   = 300;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
	localparam logic [LEN_W-1:0]    LEN_MAX       = '1;

	// GHASH predictor: running sum, key and length position, queue of digests due
	class digest_predictor;
		blk_t        hash_key;
		bit          len_in_word_one;
		blk_t        running_sum;
		blk_t        expected_digests[$];
		int unsigned mismatches;
		int unsigned blocks_absorbed;
		int unsigned digests_checked;

		function new();
			hash_key        = '0;
			len_in_word_one = 1'b0;
			running_sum     = '0;
			mismatches      = 0;
			blocks_absorbed = 0;
			digests_checked = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
			case (idx)
			REG_KEY_HIGH: hash_key[BLK_W-1:HALF_W] = value;
			REG_KEY_LOW:  hash_key[HALF_W-1:0] = value;
			REG_WORD_ONE: len_in_word_one = value[0];
			default: ;
			endcase
		endfunction

		// x^0 sits at bit 127; shifting right multiplies by x
		function blk_t mul_by_key(blk_t x);
			blk_t acc;
			blk_t v;
			acc = '0;
			v = hash_key;
			for (int i = 0; i < BLK_W; i++) begin
				if (x[BLK_W-1-i])
					acc ^= v;
				v = v[0] ? ((v >> 1) ^ RED_POLY) : (v >> 1);
			end
			return acc;
		endfunction

		function void note_transfer(item_kind_t kind, logic [HALF_W-1:0] hi,
				logic [HALF_W-1:0] lo, logic [LEN_W-1:0] len);
			logic [LENB_W-1:0] bit_len;
			blk_t              len_block;
			if (kind == KIND_DATA) begin
				running_sum = mul_by_key(running_sum ^ {hi, lo});
				blocks_absorbed++;
			end else begin
				bit_len = {len, 3'b000};
				len_block = len_in_word_one ? {32'd0, bit_len, 64'd0} : {96'd0, bit_len};
				running_sum = mul_by_key(running_sum ^ len_block);
				expected_digests.push_back(running_sum);
				running_sum = '0;
			end
		endfunction

		function void check_digest(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
			blk_t want;
			if (expected_digests.size() == 0) begin
				$error("unexpected digest %h_%h with none outstanding", hi, lo);
				mismatches++;
			end else begin
				want = expected_digests.pop_front();
				digests_checked++;
				if (hi !== want[BLK_W-1:HALF_W]) begin
					$error("digest_high: expected %h, got %h", want[BLK_W-1:HALF_W], hi);
					mismatches++;
				end
				if (lo !== want[HALF_W-1:0]) begin
					$error("digest_low: expected %h, got %h", want[HALF_W-1:0], lo);
					mismatches++;
				end
			end
		endfunction

		function int outstanding();
			return expected_digests.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [BLK_W-1:0]      m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [HALF_W-1:0]     cfg_data = '0;

	digest_predictor sb;
	int unsigned     idle_cycles = 0;
	int unsigned     items_sent = 0;
	int unsigned     settings_loaded = 0;
	int unsigned     send_idle_pct = 0;
	int unsigned     recv_stall_pct = 0;
	int unsigned     hold_req = 0;
	int unsigned     hold_seen = 0;
	int unsigned     hold_left = 0;

	ghash_authenticator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: register writes, input and output transfers, progress count
	always @(posedge clk) begin
		if (cfg_we)
			sb.set_register(cfg_index, cfg_data);
		if (m_tvalid && m_tready)
			sb.check_digest(m_tdata[63:0], m_tdata[127:64]);
		if (s_tvalid && s_tready)
			sb.note_transfer(item_kind_t'(s_tuser), s_tdata[63:0], s_tdata[127:64],
				s_tdata[156:128]);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("FAIL ghash_authenticator_core");
		$finish;
	end

	function automatic logic [HALF_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [HALF_W-1:0] rand_half();
		case ($urandom_range(9))
		0: return '0;
		1: return '1;
		default: return rand64();
		endcase
	endfunction

	function automatic logic [LEN_W-1:0] rand_len();
		case ($urandom_range(9))
		0: return '0;
		1: return LEN_MAX;
		2, 3, 4: return LEN_W'($urandom_range(300));
		default: return LEN_W'($urandom);
		endcase
	endfunction

	// valid stays high between back-to-back transfers
	task automatic send_item(item_kind_t kind, logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo,
			logic [LEN_W-1:0] len);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {3'b000, len, lo, hi};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_key(logic [HALF_W-1:0] kh, logic [HALF_W-1:0] kl, logic word_one,
			bit poke_unused);
		logic [HALF_W-1:0] word_one_data;
		drain();
		word_one_data = rand64();
		word_one_data[0] = word_one;
		cfg_we <= 1'b1;
		cfg_index <= REG_KEY_HIGH;
		cfg_data <= kh;
		@(posedge clk);
		cfg_index <= REG_KEY_LOW;
		cfg_data <= kl;
		@(posedge clk);
		cfg_index <= REG_WORD_ONE;
		cfg_data <= word_one_data;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= rand64();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// data blocks carry a random length field, which the core must ignore
	task automatic send_message(int blocks);
		for (int i = 0; i < blocks; i++)
			send_item(KIND_DATA, rand_half(), rand_half(), LEN_W'($urandom));
		send_item(KIND_FINISH, rand64(), rand64(), rand_len());
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned n);
		int unsigned target;
		int          blocks;
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
		target = items_sent + n;
		while (items_sent < target) begin
			blocks = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 4);
			send_message(blocks);
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key is zero, so any message hashes to zero
		send_item(KIND_DATA, '1, '1, LEN_MAX);
		send_item(KIND_FINISH, '0, '0, LEN_W'(5));

		program_key(rand64(), rand64(), 1'b0, 1'b0);
		send_item(KIND_DATA, '0, '0, '0);
		send_item(KIND_DATA, '1, '1, '0);
		send_item(KIND_FINISH, '0, '0, '0);
		// empty message at maximum length, block fields must be ignored
		send_item(KIND_FINISH, '1, '1, LEN_MAX);
		send_item(KIND_DATA, 64'h8000_0000_0000_0000, 64'h1, rand_len());
		send_item(KIND_FINISH, rand64(), rand64(), LEN_W'(32));

		program_key('1, '1, 1'b1, 1'b1);
		send_item(KIND_DATA, rand64(), rand64(), LEN_MAX);
		send_item(KIND_FINISH, '0, '0, LEN_MAX);
		send_item(KIND_FINISH, '0, '0, LEN_W'(1));
		send_item(KIND_DATA, '0, '0, '0);
		send_item(KIND_FINISH, '0, '0, '0);

		// key equal to the field's one element
		program_key(64'h8000_0000_0000_0000, '0, 1'b0, 1'b0);
		send_item(KIND_DATA, rand64(), rand64(), '0);
		send_item(KIND_FINISH, '0, '0, LEN_W'(16));

		// key swapped between blocks of one message; sum carries over
		send_item(KIND_DATA, rand64(), rand64(), '0);
		program_key(rand64(), rand64(), 1'b1, 1'b0);
		send_item(KIND_DATA, rand64(), rand64(), '0);
		send_item(KIND_FINISH, '0, '0, LEN_W'(32));

		program_key(rand64(), rand64(), 1'b0, 1'b0);
		run_phase(0, 0, 200);

		// output blocked for a long stretch while finishes keep coming
		drain();
		hold_req <= hold_req + 1;
		for (int i = 0; i < 6; i++)
			send_message($urandom_range(0, 1));
		drain();

		program_key(rand64(), rand64(), 1'b1, 1'b0);
		run_phase(85, 0, 200);
		program_key(rand64(), rand64(), 1'b0, 1'b1);
		run_phase(0, 85, 200);
		program_key(rand64(), rand64(), 1'b1, 1'b0);
		run_phase(33, 33, 200);
		drain();

		$display("Sent %0d items: %0d data blocks absorbed, %0d digests checked,",
			items_sent, sb.blocks_absorbed, sb.digests_checked);
		$display("%0d key/length-position settings; %s",
			settings_loaded, "free, sender-idle, receiver-stall, mixed, backpressure");
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("PASS ghash_authenticator_core");
		else
			$display("FAIL ghash_authenticator_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/gha_pkg.sv
design/gha_digit_mul.sv
design/ghash_authenticator_core.sv
test/tb.sv
